// File: rtl/cls_pkg.sv
// Shared opcodes, codes, field layout and types for the command list sequencer.
`default_nettype none

package cls_pkg;

    // Command opcodes
    localparam logic [5:0] OP_ENTER      = 6'h00;
    localparam logic [5:0] OP_DROP_JUMP  = 6'h01;
    localparam logic [5:0] OP_EXIT       = 6'h02;
    localparam logic [5:0] OP_SLEEP      = 6'h03;
    localparam logic [5:0] OP_SLEEP2     = 6'h04;
    localparam logic [5:0] OP_JUMP       = 6'h05;
    localparam logic [5:0] OP_CALL       = 6'h06;
    localparam logic [5:0] OP_RETURN     = 6'h07;
    localparam logic [5:0] OP_REPEAT     = 6'h08;
    localparam logic [5:0] OP_REPEAT_END = 6'h09;
    localparam logic [5:0] OP_LOOP_BEGIN = 6'h0A;
    localparam logic [5:0] OP_LOOP_UNTIL = 6'h0B;
    localparam logic [5:0] OP_JUMP_IF    = 6'h0C;
    localparam logic [5:0] OP_CALL_IF    = 6'h0D;
    localparam logic [5:0] OP_SKIP_IF    = 6'h0E;
    localparam logic [5:0] OP_SKIP       = 6'h0F;
    localparam logic [5:0] OP_SKIP_NOP   = 6'h10;
    localparam logic [5:0] OP_CALL_EXT   = 6'h11;
    localparam logic [5:0] OP_CALL_LOOP  = 6'h12;
    localparam logic [5:0] OP_SET_REG    = 6'h13;
    localparam logic [5:0] OP_VAR_ACCESS = 6'h3C;
    localparam logic [5:0] OP_MAX        = 6'h3C;

    // Compare ops
    localparam logic [7:0] CMP_AND  = 8'd0;
    localparam logic [7:0] CMP_NAND = 8'd1;
    localparam logic [7:0] CMP_EQ   = 8'd2;
    localparam logic [7:0] CMP_NE   = 8'd3;
    localparam logic [7:0] CMP_LT   = 8'd4;
    localparam logic [7:0] CMP_LE   = 8'd5;
    localparam logic [7:0] CMP_GT   = 8'd6;
    localparam logic [7:0] CMP_GE   = 8'd7;

    localparam logic [7:0] VAR_MODE_SET = 8'd0;
    localparam logic [7:0] VAR_MAX_IDX  = 8'd4;

    typedef logic [1:0] t_status;
    localparam t_status ST_RUN    = 2'd0;
    localparam t_status ST_PAUSE  = 2'd1;
    localparam t_status ST_PAUSE2 = 2'd2;
    localparam t_status ST_ERROR  = 2'd3;

    typedef enum logic [1:0] {
        SKIP_NONE       = 2'd0,
        SKIP_AFTER_IF   = 2'd1,
        SKIP_AFTER_SKIP = 2'd2
    } t_skip;

    // Input tdata layout, lowest bit first
    localparam int IN_CMD_LSB  = 0;
    localparam int IN_ADDR_LSB = 6;
    localparam int IN_SIZE_LSB = 38;
    localparam int IN_OP_LSB   = 46;
    localparam int IN_HALF_LSB = 54;
    localparam int IN_WORD_LSB = 70;
    localparam int IN_TGT_LSB  = 102;
    localparam int IN_EXT_LSB  = 134;
    localparam int IN_W        = 168;

    // Output tdata layout
    localparam int OUT_W = 72;

endpackage

`default_nettype wire

// File: rtl/command_list_sequencer_core.sv
// Command list sequencer: control unit of a command-list interpreter.
//
// Channel   Dir  Signals                          Transaction
// s         in   i_s_tvalid/o_s_tready/i_s_tdata   one fetched command
// m         out  o_m_tvalid/i_m_tready/o_m_tdata   next address, status, register
// cfg       in   i_cfg_valid/o_cfg_ready/i_cfg_data size_shift write
//
// One command per clock sustained while the result side is not stalled. A command
// is captured in the input register, then resolved into the result register.
// The critical path runs from the command register through next-state logic
// into the return stack read address and the bypassed read of the two banks.
// Reset (synchronous, active low) clears stack pointers, counters, register
// and skip mode; the return stack itself is not cleared. A stalled result
// holds the input register, which holds s (o_s_tready low).
`default_nettype none

module command_list_sequencer_core #(
    parameter int STACK_DEPTH = 32
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_s_tvalid,
    output logic                       o_s_tready,
    // command[5:0], cmd_addr[37:6], cmd_size[45:38], cond_op[53:46],
    // half_arg[69:54], word_arg[101:70], target_addr[133:102],
    // external_value[165:134], zero fill[167:166]
    input  wire  [cls_pkg::IN_W-1:0]   i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire                        i_m_tready,
    // next_addr[31:0], status[33:32], hand_off[34], reg_value[66:35],
    // was_skipped[67], zero fill[71:68]
    output logic [cls_pkg::OUT_W-1:0]  o_m_tdata,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire                        i_cfg_data
);
    import cls_pkg::*;

    localparam int TW = $clog2(STACK_DEPTH + 1);  // stack pointer width
    localparam int AW = $clog2(STACK_DEPTH);      // entry address width
    localparam int DH = (STACK_DEPTH + 1) / 2;    // entries per bank
    localparam int IW = AW - 1;                   // bank index width

    // Architectural state
    logic [TW-1:0]        r_top, n_top;
    logic [TW-1:0]        r_fb, n_fb;
    logic signed [31:0]   r_reg, n_reg;
    logic [15:0]          r_sl, n_sl;
    logic [15:0]          r_sl2, n_sl2;
    t_skip                r_skip, n_skip;
    logic                 r_size_shift;

    // Input register
    logic                 r_v;
    logic [5:0]           r_cmd;
    logic [31:0]          r_addr;
    logic [7:0]           r_size;
    logic [7:0]           r_op;
    logic [15:0]          r_half;
    logic signed [31:0]   r_word;
    logic [31:0]          r_tgt;
    logic signed [31:0]   r_ext;

    // Result register
    logic                 r_o_v;
    logic [31:0]          r_o_next;
    t_status              r_o_status;
    logic                 r_o_hand;
    logic signed [31:0]   r_o_reg;
    logic                 r_o_skip;

    // Return stack: two banks (even / odd entries) so two pushes land in one cycle
    logic [31:0]          r_bank_even [DH];
    logic [31:0]          r_bank_odd  [DH];
    // Registered reads: top-based and frame-based port per bank
    logic [31:0]          r_rd_et, r_rd_ef, r_rd_ot, r_rd_of;

    logic                 exec_fire;
    logic                 accept;

    // Execute results
    logic [TW-1:0]        x_top, x_fb;
    logic signed [31:0]   x_reg;
    logic [15:0]          x_sl, x_sl2;
    t_skip                x_skip;
    logic [31:0]          x_dest;
    t_status              x_status;
    logic                 x_hand, x_skipped, x_err;
    logic                 we_a, we_b;
    logic [TW-1:0]        wa_a, wa_b;
    logic [31:0]          wd_a, wd_b;

    // Bank write / read ports
    logic                 we_e, we_o;
    logic [IW-1:0]        wa_e, wa_o;
    logic [31:0]          wd_e, wd_o;
    logic [TW-1:0]        ta1, ta2, fa1, fa2;
    logic [IW-1:0]        ra_et, ra_ot, ra_ef, ra_of;

    // Stack views for the command in the input register
    logic [TW-1:0]        p1_addr, f1_addr;
    logic [31:0]          peek1, peek2, fb_nb, fb_ra;
    logic [31:0]          next_seq;
    logic signed [31:0]   half32;
    logic                 cond;

    function automatic logic eval_cond(input logic [7:0] op,
                                       input logic signed [31:0] r,
                                       input logic signed [31:0] arg);
        logic res;
        unique case (op)
            CMP_AND:  res = (r & arg) != 32'sd0;
            CMP_NAND: res = (r & arg) == 32'sd0;
            CMP_EQ:   res = r == arg;
            CMP_NE:   res = r != arg;
            CMP_LT:   res = r < arg;
            CMP_LE:   res = r <= arg;
            CMP_GT:   res = r > arg;
            CMP_GE:   res = r >= arg;
            default:  res = 1'b0;
        endcase
        return res;
    endfunction

    assign exec_fire   = r_v && (!r_o_v || i_m_tready);
    assign o_s_tready  = !r_v || exec_fire;
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_o_v;
    assign o_m_tdata   = {4'b0, r_o_skip, r_o_reg, r_o_hand, r_o_status, r_o_next};

    // Stack views: parity of the address picks the bank
    assign p1_addr  = r_top - TW'(1);
    assign f1_addr  = r_fb - TW'(1);
    assign peek1    = p1_addr[0] ? r_rd_ot : r_rd_et;
    assign peek2    = p1_addr[0] ? r_rd_et : r_rd_ot;
    assign fb_nb    = f1_addr[0] ? r_rd_of : r_rd_ef;
    assign fb_ra    = f1_addr[0] ? r_rd_ef : r_rd_of;

    assign next_seq = r_addr + ({24'b0, r_size} << r_size_shift);
    assign half32   = {{16{r_half[15]}}, r_half};
    assign cond     = eval_cond(r_op, r_reg, r_word);

    always_comb begin
        logic [15:0] cnt;
        logic [31:0] val;
        x_top     = r_top;
        x_fb      = r_fb;
        x_reg     = r_reg;
        x_sl      = r_sl;
        x_sl2     = r_sl2;
        x_skip    = r_skip;
        x_dest    = next_seq;
        x_status  = ST_RUN;
        x_hand    = 1'b0;
        x_skipped = 1'b0;
        x_err     = 1'b0;
        we_a      = 1'b0;
        we_b      = 1'b0;
        wa_a      = r_top;
        wa_b      = r_top + TW'(1);
        wd_a      = next_seq;
        wd_b      = 32'd0;
        cnt       = 16'd0;
        val       = peek1 - 32'd1;

        if (r_skip != SKIP_NONE) begin
            x_skipped = 1'b1;
            if (r_skip == SKIP_AFTER_IF && (r_cmd == OP_SKIP || r_cmd == OP_SKIP_NOP)) begin
                x_skip = SKIP_AFTER_IF;
            end else if (r_skip == SKIP_AFTER_SKIP && r_cmd == OP_SKIP_NOP) begin
                x_skip = SKIP_AFTER_SKIP;
            end else begin
                x_skip = SKIP_NONE;
            end
        end else begin
            unique case (r_cmd)
                OP_ENTER: begin
                    if ((TW+1)'(r_top) + (TW+1)'(2) > (TW+1)'(STACK_DEPTH)) begin
                        x_err = 1'b1;
                    end else begin
                        we_a   = 1'b1;
                        we_b   = 1'b1;
                        wd_b   = 32'(r_fb);
                        x_top  = r_top + TW'(2);
                        x_fb   = r_top + TW'(2);
                        x_dest = r_tgt;
                        x_hand = 1'b1;
                    end
                end
                OP_DROP_JUMP: begin
                    x_top  = r_fb;
                    x_dest = r_tgt;
                    x_hand = 1'b1;
                end
                OP_EXIT: begin
                    if (r_fb < TW'(2) || r_fb > TW'(STACK_DEPTH)) begin
                        x_err = 1'b1;
                    end else if (fb_nb > 32'(STACK_DEPTH)) begin
                        x_err = 1'b1;
                    end else begin
                        x_top  = r_fb - TW'(2);
                        x_fb   = fb_nb[TW-1:0];
                        x_dest = fb_ra;
                        x_hand = 1'b1;
                    end
                end
                OP_SLEEP, OP_SLEEP2: begin
                    x_status = (r_cmd == OP_SLEEP) ? ST_PAUSE : ST_PAUSE2;
                    x_dest   = r_addr;
                    cnt      = (r_cmd == OP_SLEEP) ? r_sl : r_sl2;
                    if (cnt == 16'd0) begin
                        cnt = r_half;
                    end else begin
                        cnt = cnt - 16'd1;
                        if (cnt == 16'd0) begin
                            x_dest   = next_seq;
                            x_status = ST_RUN;
                        end
                    end
                    if (r_cmd == OP_SLEEP) begin
                        x_sl = cnt;
                    end else begin
                        x_sl2 = cnt;
                    end
                end
                OP_JUMP: begin
                    x_dest = r_tgt;
                end
                OP_CALL: begin
                    if (r_top >= TW'(STACK_DEPTH)) begin
                        x_err = 1'b1;
                    end else begin
                        we_a   = 1'b1;
                        x_top  = r_top + TW'(1);
                        x_dest = r_tgt;
                    end
                end
                OP_RETURN: begin
                    if (r_top < TW'(1)) begin
                        x_err = 1'b1;
                    end else begin
                        x_dest = peek1;
                        x_top  = r_top - TW'(1);
                    end
                end
                OP_REPEAT: begin
                    if ((TW+1)'(r_top) + (TW+1)'(2) > (TW+1)'(STACK_DEPTH)) begin
                        x_err = 1'b1;
                    end else begin
                        we_a  = 1'b1;
                        we_b  = 1'b1;
                        wd_b  = half32;
                        x_top = r_top + TW'(2);
                    end
                end
                OP_REPEAT_END: begin
                    if (r_top < TW'(2)) begin
                        x_err = 1'b1;
                    end else if (peek1 == 32'd0) begin
                        // zero count loops forever
                        x_dest = peek2;
                    end else if (val != 32'd0) begin
                        we_a   = 1'b1;
                        wa_a   = p1_addr;
                        wd_a   = val;
                        x_dest = peek2;
                    end else begin
                        x_top = r_top - TW'(2);
                    end
                end
                OP_LOOP_BEGIN: begin
                    if ((TW+1)'(r_top) + (TW+1)'(2) > (TW+1)'(STACK_DEPTH)) begin
                        x_err = 1'b1;
                    end else begin
                        we_a  = 1'b1;
                        we_b  = 1'b1;
                        x_top = r_top + TW'(2);
                    end
                end
                OP_LOOP_UNTIL: begin
                    if (r_top < TW'(2)) begin
                        x_err = 1'b1;
                    end else if (cond) begin
                        x_top = r_top - TW'(2);
                    end else begin
                        x_dest = peek2;
                    end
                end
                OP_JUMP_IF: begin
                    if (cond) begin
                        x_dest = r_tgt;
                    end
                end
                OP_CALL_IF: begin
                    if (cond) begin
                        if (r_top >= TW'(STACK_DEPTH)) begin
                            x_err = 1'b1;
                        end else begin
                            we_a   = 1'b1;
                            x_top  = r_top + TW'(1);
                            x_dest = r_tgt;
                        end
                    end
                end
                OP_SKIP_IF: begin
                    if (!cond) begin
                        x_skip = SKIP_AFTER_IF;
                    end
                end
                OP_SKIP: begin
                    x_skip = SKIP_AFTER_SKIP;
                end
                OP_SKIP_NOP: begin
                    x_dest = next_seq;
                end
                OP_CALL_EXT: begin
                    x_reg  = r_ext;
                    x_hand = 1'b1;
                end
                OP_CALL_LOOP: begin
                    x_reg  = r_ext;
                    x_hand = 1'b1;
                    if (r_ext == 32'sd0) begin
                        x_status = ST_PAUSE;
                        x_dest   = r_addr;
                    end
                end
                OP_SET_REG: begin
                    x_reg = half32;
                end
                OP_VAR_ACCESS: begin
                    x_hand = 1'b1;
                    if (r_op != VAR_MODE_SET && r_half[7:0] <= VAR_MAX_IDX) begin
                        x_reg = r_ext;
                    end
                end
                default: begin
                    if (r_cmd > OP_MAX) begin
                        x_err = 1'b1;
                    end else begin
                        x_hand = 1'b1;
                    end
                end
            endcase
        end

        // Error: no state change, stay on this command
        if (x_err) begin
            x_top    = r_top;
            x_fb     = r_fb;
            x_reg    = r_reg;
            x_sl     = r_sl;
            x_sl2    = r_sl2;
            x_skip   = r_skip;
            we_a     = 1'b0;
            we_b     = 1'b0;
            x_dest   = r_addr;
            x_status = ST_ERROR;
            x_hand   = 1'b0;
        end
    end

    // Next state
    assign n_top  = exec_fire ? x_top  : r_top;
    assign n_fb   = exec_fire ? x_fb   : r_fb;
    assign n_reg  = exec_fire ? x_reg  : r_reg;
    assign n_sl   = exec_fire ? x_sl   : r_sl;
    assign n_sl2  = exec_fire ? x_sl2  : r_sl2;
    assign n_skip = exec_fire ? x_skip : r_skip;

    // Map the two write slots onto the banks; slots differ in parity whenever both are written
    always_comb begin
        we_e = exec_fire && ((we_a && !wa_a[0]) || (we_b && !wa_b[0]));
        we_o = exec_fire && ((we_a && wa_a[0]) || (we_b && wa_b[0]));
        wa_e = (we_a && !wa_a[0]) ? wa_a[AW-1:1] : wa_b[AW-1:1];
        wd_e = (we_a && !wa_a[0]) ? wd_a : wd_b;
        wa_o = (we_a && wa_a[0])  ? wa_a[AW-1:1] : wa_b[AW-1:1];
        wd_o = (we_a && wa_a[0])  ? wd_a : wd_b;
    end

    // Read addresses follow the next state so the views are current each cycle
    assign ta1   = n_top - TW'(1);
    assign ta2   = n_top - TW'(2);
    assign fa1   = n_fb - TW'(1);
    assign fa2   = n_fb - TW'(2);
    assign ra_et = ta1[0] ? ta2[AW-1:1] : ta1[AW-1:1];
    assign ra_ot = ta1[0] ? ta1[AW-1:1] : ta2[AW-1:1];
    assign ra_ef = fa1[0] ? fa2[AW-1:1] : fa1[AW-1:1];
    assign ra_of = fa1[0] ? fa1[AW-1:1] : fa2[AW-1:1];

    always_ff @(posedge i_clk) begin
        if (we_e) begin
            r_bank_even[wa_e] <= wd_e;
        end
        r_rd_et <= (we_e && wa_e == ra_et) ? wd_e : r_bank_even[ra_et];
        r_rd_ef <= (we_e && wa_e == ra_ef) ? wd_e : r_bank_even[ra_ef];
    end

    always_ff @(posedge i_clk) begin
        if (we_o) begin
            r_bank_odd[wa_o] <= wd_o;
        end
        r_rd_ot <= (we_o && wa_o == ra_ot) ? wd_o : r_bank_odd[ra_ot];
        r_rd_of <= (we_o && wa_o == ra_of) ? wd_o : r_bank_odd[ra_of];
    end

    // State and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top        <= '0;
            r_fb         <= '0;
            r_reg        <= '0;
            r_sl         <= '0;
            r_sl2        <= '0;
            r_skip       <= SKIP_NONE;
            r_size_shift <= 1'b0;
            r_v          <= 1'b0;
            r_o_v        <= 1'b0;
        end else begin
            r_top  <= n_top;
            r_fb   <= n_fb;
            r_reg  <= n_reg;
            r_sl   <= n_sl;
            r_sl2  <= n_sl2;
            r_skip <= n_skip;
            if (i_cfg_valid) begin
                r_size_shift <= i_cfg_data;
            end
            if (accept) begin
                r_v <= 1'b1;
            end else if (exec_fire) begin
                r_v <= 1'b0;
            end
            if (exec_fire) begin
                r_o_v <= 1'b1;
            end else if (i_m_tready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_s_tdata[IN_CMD_LSB +: 6];
            r_addr <= i_s_tdata[IN_ADDR_LSB +: 32];
            r_size <= i_s_tdata[IN_SIZE_LSB +: 8];
            r_op   <= i_s_tdata[IN_OP_LSB +: 8];
            r_half <= i_s_tdata[IN_HALF_LSB +: 16];
            r_word <= i_s_tdata[IN_WORD_LSB +: 32];
            r_tgt  <= i_s_tdata[IN_TGT_LSB +: 32];
            r_ext  <= i_s_tdata[IN_EXT_LSB +: 32];
        end
        if (exec_fire) begin
            r_o_next   <= x_dest;
            r_o_status <= x_status;
            r_o_hand   <= x_hand;
            r_o_reg    <= x_reg;
            r_o_skip   <= x_skipped;
        end
    end

    // Checks
    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TW'(STACK_DEPTH) && r_fb <= TW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_err_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && x_err) |=> (r_top == $past(r_top) && r_fb == $past(r_fb)
                                  && r_reg == $past(r_reg) && r_skip == $past(r_skip)))
        else $error("error command changed state");

    a_skip_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_skip) |-> (r_o_status == ST_RUN && !r_o_hand))
        else $error("skipped command with effect");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && r_o_v && !i_m_tready) |-> !o_s_tready)
        else $error("command taken while result stalled");

    a_one_write_per_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && we_a && we_b) |-> (wa_a[0] != wa_b[0]))
        else $error("two writes to one bank");

endmodule

`default_nettype wire

// File: tb/tb_command_list_sequencer_core.sv
// Self-checking testbench for the command list sequencer core.
`timescale 1ns / 100ps

module tb_command_list_sequencer_core;
    import cls_pkg::*;

    localparam int DEPTH       = 32;
    localparam int HOLD_CYCLES = 300;

    // Opcodes the block only flags for the external handler, and the top of the opcode space
    localparam logic [5:0] OP_HANDLER_FIRST = 6'h14;
    localparam logic [5:0] OP_HANDLER_LAST  = 6'h3B;
    localparam logic [5:0] OP_TOP_CODE      = 6'h3F;

    // One fetched command, as the s-side transaction carries it
    typedef struct packed {
        logic [5:0]  opcode;
        logic [31:0] addr;
        logic [7:0]  size;
        logic [7:0]  cmp;
        logic [15:0] half;
        logic [31:0] word;
        logic [31:0] target;
        logic [31:0] ext;
    } t_cmd_item;

    // One result, as the m-side transaction carries it
    typedef struct packed {
        logic [31:0] next_addr;
        t_status     status;
        logic        hand_off;
        logic [31:0] reg_value;
        logic        was_skipped;
    } t_cmd_result;

    typedef struct packed {
        t_cmd_item   item;
        logic        typed;
        t_cmd_result want;
    } t_dir_row;

    logic               clk;
    logic               rst_n;
    logic               s_valid;
    logic [IN_W-1:0]    s_data;
    logic               m_ready;
    logic               cfg_valid;
    logic               cfg_data;
    logic               s_ready;
    logic               m_valid;
    logic [OUT_W-1:0]   m_data;
    logic               cfg_ready;

    // Sequencer state as the testbench tracks it
    logic [31:0]  ret_stack   [DEPTH];
    bit           ret_written [DEPTH];
    int unsigned  depth;
    int unsigned  frame;
    logic [31:0]  script_reg;
    logic [15:0]  nap_first;
    logic [15:0]  nap_second;
    t_skip        skip_state;
    logic         size_shift;

    t_cmd_result  pending_results[$];
    t_dir_row     dir_rows[$];
    int           fail_count;
    bit           steady;     // no idling on either side while set
    bit           hold_req;   // asks the receiver for one long hold-off

    command_list_sequencer_core #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_cmd_item make_command(logic [5:0] opc, logic [31:0] addr,
                                               logic [7:0] size, logic [7:0] cmp,
                                               logic [15:0] half, logic [31:0] word,
                                               logic [31:0] target, logic [31:0] ext);
        t_cmd_item c;
        c.opcode = opc;
        c.addr   = addr;
        c.size   = size;
        c.cmp    = cmp;
        c.half   = half;
        c.word   = word;
        c.target = target;
        c.ext    = ext;
        return c;
    endfunction

    function automatic t_cmd_result outcome(logic [31:0] next_addr, t_status status,
                                            logic hand_off, logic [31:0] reg_value,
                                            logic was_skipped);
        t_cmd_result r;
        r.next_addr   = next_addr;
        r.status      = status;
        r.hand_off    = hand_off;
        r.reg_value   = reg_value;
        r.was_skipped = was_skipped;
        return r;
    endfunction

    task automatic add_row(t_cmd_item c, logic typed = 1'b0, t_cmd_result want = '0);
        t_dir_row row;
        row.item  = c;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Compare of the script register against a command operand
    function automatic logic cond_holds(logic [7:0] cmp, logic [31:0] arg);
        case (cmp)
            CMP_AND:  return (script_reg & arg) != 0;
            CMP_NAND: return (script_reg & arg) == 0;
            CMP_EQ:   return script_reg == arg;
            CMP_NE:   return script_reg != arg;
            CMP_LT:   return $signed(script_reg) <  $signed(arg);
            CMP_LE:   return $signed(script_reg) <= $signed(arg);
            CMP_GT:   return $signed(script_reg) >  $signed(arg);
            CMP_GE:   return $signed(script_reg) >= $signed(arg);
            default:  return 1'b0;
        endcase
    endfunction

    function automatic void push_entry(logic [31:0] v);
        ret_stack[depth]   = v;
        ret_written[depth] = 1'b1;
        depth++;
    endfunction

    // Runs one command through the tracked state and returns what the block must answer
    function automatic t_cmd_result advance_sequencer(t_cmd_item c);
        t_cmd_result r;
        logic [31:0] fall_thru;
        logic [31:0] half_sx;
        logic [31:0] nb;
        logic [31:0] ra;
        logic [31:0] loops;
        logic [15:0] cnt;
        logic        fail;

        fall_thru     = c.addr + ({24'd0, c.size} << size_shift);
        half_sx       = {{16{c.half[15]}}, c.half};
        r.next_addr   = fall_thru;
        r.status      = ST_RUN;
        r.hand_off    = 1'b0;
        r.was_skipped = 1'b0;
        fail          = 1'b0;

        if (skip_state != SKIP_NONE) begin
            // consumed without effect; skip chains continue on the skip opcodes only
            r.was_skipped = 1'b1;
            if (!((skip_state == SKIP_AFTER_IF &&
                   (c.opcode == OP_SKIP || c.opcode == OP_SKIP_NOP)) ||
                  (skip_state == SKIP_AFTER_SKIP && c.opcode == OP_SKIP_NOP)))
                skip_state = SKIP_NONE;
        end else begin
            case (c.opcode)
                OP_ENTER: begin
                    if (depth + 2 > DEPTH) begin
                        fail = 1'b1;
                    end else begin
                        push_entry(fall_thru);
                        push_entry(frame);
                        frame       = depth;
                        r.next_addr = c.target;
                        r.hand_off  = 1'b1;
                    end
                end
                OP_DROP_JUMP: begin
                    depth       = frame;
                    r.next_addr = c.target;
                    r.hand_off  = 1'b1;
                end
                OP_EXIT: begin
                    if (frame < 2 || frame > DEPTH) begin
                        fail = 1'b1;
                    end else begin
                        nb = ret_stack[frame - 1];
                        ra = ret_stack[frame - 2];
                        if (nb > DEPTH) begin
                            fail = 1'b1;
                        end else begin
                            depth       = frame - 2;
                            frame       = nb;
                            r.next_addr = ra;
                            r.hand_off  = 1'b1;
                        end
                    end
                end
                OP_SLEEP, OP_SLEEP2: begin
                    r.status    = (c.opcode == OP_SLEEP) ? ST_PAUSE : ST_PAUSE2;
                    r.next_addr = c.addr;
                    cnt = (c.opcode == OP_SLEEP) ? nap_first : nap_second;
                    if (cnt == 0) begin
                        cnt = c.half;
                    end else begin
                        cnt = cnt - 1'b1;
                        if (cnt == 0) begin
                            r.next_addr = fall_thru;
                            r.status    = ST_RUN;
                        end
                    end
                    if (c.opcode == OP_SLEEP)
                        nap_first = cnt;
                    else
                        nap_second = cnt;
                end
                OP_JUMP: r.next_addr = c.target;
                OP_CALL: begin
                    if (depth >= DEPTH) begin
                        fail = 1'b1;
                    end else begin
                        push_entry(fall_thru);
                        r.next_addr = c.target;
                    end
                end
                OP_RETURN: begin
                    if (depth < 1) begin
                        fail = 1'b1;
                    end else begin
                        r.next_addr = ret_stack[depth - 1];
                        depth--;
                    end
                end
                OP_REPEAT: begin
                    if (depth + 2 > DEPTH) begin
                        fail = 1'b1;
                    end else begin
                        push_entry(fall_thru);
                        push_entry(half_sx);
                    end
                end
                OP_REPEAT_END: begin
                    if (depth < 2) begin
                        fail = 1'b1;
                    end else begin
                        loops = ret_stack[depth - 1];
                        if (loops == 0) begin
                            // zero count never runs out
                            r.next_addr = ret_stack[depth - 2];
                        end else begin
                            loops = loops - 1;
                            if (loops != 0) begin
                                ret_stack[depth - 1] = loops;
                                r.next_addr = ret_stack[depth - 2];
                            end else begin
                                depth -= 2;
                            end
                        end
                    end
                end
                OP_LOOP_BEGIN: begin
                    if (depth + 2 > DEPTH) begin
                        fail = 1'b1;
                    end else begin
                        push_entry(fall_thru);
                        push_entry(32'd0);
                    end
                end
                OP_LOOP_UNTIL: begin
                    if (depth < 2)
                        fail = 1'b1;
                    else if (cond_holds(c.cmp, c.word))
                        depth -= 2;
                    else
                        r.next_addr = ret_stack[depth - 2];
                end
                OP_JUMP_IF: begin
                    if (cond_holds(c.cmp, c.word))
                        r.next_addr = c.target;
                end
                OP_CALL_IF: begin
                    if (cond_holds(c.cmp, c.word)) begin
                        if (depth >= DEPTH) begin
                            fail = 1'b1;
                        end else begin
                            push_entry(fall_thru);
                            r.next_addr = c.target;
                        end
                    end
                end
                OP_SKIP_IF: begin
                    if (!cond_holds(c.cmp, c.word))
                        skip_state = SKIP_AFTER_IF;
                end
                OP_SKIP: skip_state = SKIP_AFTER_SKIP;
                OP_SKIP_NOP: begin
                end
                OP_CALL_EXT: begin
                    script_reg = c.ext;
                    r.hand_off = 1'b1;
                end
                OP_CALL_LOOP: begin
                    script_reg = c.ext;
                    r.hand_off = 1'b1;
                    if (c.ext == 0) begin
                        r.status    = ST_PAUSE;
                        r.next_addr = c.addr;
                    end
                end
                OP_SET_REG: script_reg = half_sx;
                OP_VAR_ACCESS: begin
                    r.hand_off = 1'b1;
                    if (c.cmp != VAR_MODE_SET && c.half[7:0] <= VAR_MAX_IDX)
                        script_reg = c.ext;
                end
                default: begin
                    if (c.opcode > OP_MAX)
                        fail = 1'b1;
                    else
                        r.hand_off = 1'b1;
                end
            endcase
        end

        // errors leave every piece of state alone and park on the bad command
        if (fail) begin
            r.next_addr = c.addr;
            r.status    = ST_ERROR;
            r.hand_off  = 1'b0;
        end
        r.reg_value = script_reg;
        return r;
    endfunction

    function automatic logic [5:0] misc_opcode();
        if ($urandom_range(99) < 40)
            return 6'($urandom_range(OP_TOP_CODE, 0));
        return 6'($urandom_range(OP_SET_REG, 0));
    endfunction

    // Offers one command on s, waits for its transaction, then queues the expected result
    task automatic issue_command(t_cmd_item c, logic typed = 1'b0, t_cmd_result want = '0);
        t_cmd_result      r;
        logic             stale;
        logic [IN_W-1:0]  packed_cmd;

        // a read of a stack entry never written is not allowed; send a no-op instead
        stale = 1'b0;
        if (skip_state == SKIP_NONE) begin
            case (c.opcode)
                OP_EXIT:
                    if (frame >= 2 && frame <= DEPTH)
                        stale = !(ret_written[frame - 1] && ret_written[frame - 2]);
                OP_RETURN:
                    if (depth >= 1)
                        stale = !ret_written[depth - 1];
                OP_REPEAT_END:
                    if (depth >= 2)
                        stale = !(ret_written[depth - 1] && ret_written[depth - 2]);
                OP_LOOP_UNTIL:
                    if (depth >= 2 && !cond_holds(c.cmp, c.word))
                        stale = !ret_written[depth - 2];
                default: ;
            endcase
        end
        if (stale)
            c.opcode = OP_SKIP_NOP;

        // idle cycle by cycle, about 11 in a hundred
        while (!steady && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        packed_cmd                     = '0;
        packed_cmd[IN_CMD_LSB  +: 6]   = c.opcode;
        packed_cmd[IN_ADDR_LSB +: 32]  = c.addr;
        packed_cmd[IN_SIZE_LSB +: 8]   = c.size;
        packed_cmd[IN_OP_LSB   +: 8]   = c.cmp;
        packed_cmd[IN_HALF_LSB +: 16]  = c.half;
        packed_cmd[IN_WORD_LSB +: 32]  = c.word;
        packed_cmd[IN_TGT_LSB  +: 32]  = c.target;
        packed_cmd[IN_EXT_LSB  +: 32]  = c.ext;
        s_valid <= 1'b1;
        s_data  <= packed_cmd;
        do @(posedge clk); while (!s_ready);

        r = advance_sequencer(c);
        pending_results.push_back(typed ? want : r);
    endtask

    // Waits until every result is back, then lets the pipeline go quiet
    task automatic settle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_shift(logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        size_shift  = v;
    endtask

    // Random traffic, mostly short well-formed programs with random content
    task automatic run_random(int unsigned count);
        int unsigned sent;
        int unsigned kind;
        int unsigned k;
        int unsigned pick;
        logic [5:0]  plan[$];
        logic [5:0]  opc;
        t_cmd_item   c;

        sent = 0;
        while (sent < count) begin
            plan.delete();
            kind = $urandom_range(99);
            if (kind < 12) begin
                // sleep burst on one counter
                opc = $urandom_range(1) ? OP_SLEEP : OP_SLEEP2;
                repeat ($urandom_range(6, 1)) plan.push_back(opc);
            end else if (kind < 24) begin
                plan.push_back(OP_REPEAT);
                repeat ($urandom_range(5, 1)) plan.push_back(OP_REPEAT_END);
            end else if (kind < 36) begin
                plan.push_back(OP_LOOP_BEGIN);
                repeat ($urandom_range(4, 1)) begin
                    plan.push_back($urandom_range(1) ? OP_SET_REG : OP_CALL_EXT);
                    plan.push_back(OP_LOOP_UNTIL);
                end
            end else if (kind < 50) begin
                plan.push_back($urandom_range(1) ? OP_CALL : OP_CALL_IF);
                repeat ($urandom_range(3, 0)) plan.push_back(misc_opcode());
                if ($urandom_range(3) != 0)
                    plan.push_back(OP_RETURN);
            end else if (kind < 62) begin
                plan.push_back(OP_ENTER);
                repeat ($urandom_range(2, 0)) begin
                    pick = $urandom_range(2);
                    plan.push_back(pick == 0 ? OP_REPEAT : pick == 1 ? OP_CALL : OP_LOOP_BEGIN);
                end
                pick = $urandom_range(3);
                if (pick < 2) begin
                    plan.push_back(OP_EXIT);
                end else if (pick == 2) begin
                    plan.push_back(OP_DROP_JUMP);
                    plan.push_back(OP_EXIT);
                end
            end else if (kind < 74) begin
                plan.push_back($urandom_range(1) ? OP_SKIP_IF : OP_SKIP);
                repeat ($urandom_range(4, 1)) begin
                    pick = $urandom_range(2);
                    plan.push_back(pick == 0 ? OP_SKIP : pick == 1 ? OP_SKIP_NOP : misc_opcode());
                end
            end else if (kind < 82) begin
                // unwind whatever has piled up on the stack
                repeat ($urandom_range(5, 2)) begin
                    pick = $urandom_range(3);
                    plan.push_back(pick == 0 ? OP_RETURN : pick == 1 ? OP_EXIT :
                                   pick == 2 ? OP_REPEAT_END : OP_LOOP_UNTIL);
                end
            end else if (kind < 92) begin
                repeat ($urandom_range(3, 1)) begin
                    pick = $urandom_range(5);
                    case (pick)
                        0:       plan.push_back(OP_JUMP);
                        1:       plan.push_back(OP_JUMP_IF);
                        2:       plan.push_back(OP_SET_REG);
                        3:       plan.push_back(OP_CALL_LOOP);
                        4:       plan.push_back(OP_VAR_ACCESS);
                        default: plan.push_back(OP_CALL_EXT);
                    endcase
                end
            end else begin
                plan.push_back(6'($urandom_range(OP_TOP_CODE, 0)));
            end

            while (plan.size() != 0) begin
                c.opcode = plan.pop_front();
                c.addr   = $urandom;
                c.size   = 8'($urandom_range(255, 0));
                c.cmp    = ($urandom_range(99) < 85) ? 8'($urandom_range(CMP_GE, CMP_AND))
                                                     : 8'($urandom_range(255, 0));
                c.half   = 16'($urandom);
                if ((c.opcode == OP_SLEEP || c.opcode == OP_SLEEP2 || c.opcode == OP_REPEAT)
                    && $urandom_range(9) != 0)
                    c.half = 16'($urandom_range(3, 0));
                if (c.opcode == OP_VAR_ACCESS) begin
                    if ($urandom_range(4) != 0)
                        c.half[7:0] = 8'($urandom_range(7, 0));
                    if ($urandom_range(1))
                        c.cmp = VAR_MODE_SET;
                end
                // operands near the register so every compare goes both ways
                case ($urandom_range(3))
                    0:       c.word = script_reg;
                    1:       c.word = script_reg + 1;
                    2:       c.word = script_reg - 1;
                    default: c.word = $urandom;
                endcase
                c.target = $urandom;
                c.ext    = ($urandom_range(4) == 0) ? 32'd0 : $urandom;
                issue_command(c);
                sent++;
            end
        end
    endtask

    // Result checker: every m-side transaction against the oldest expectation
    always @(posedge clk) begin : result_check
        t_cmd_result got;
        t_cmd_result want;
        if (rst_n && m_valid && m_ready) begin
            got.next_addr   = m_data[31:0];
            got.status      = m_data[33:32];
            got.hand_off    = m_data[34];
            got.reg_value   = m_data[66:35];
            got.was_skipped = m_data[67];
            if (pending_results.size() == 0) begin
                $error("result transaction with no command outstanding: next_addr %h",
                       got.next_addr);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.next_addr !== want.next_addr) begin
                    $error("next_addr: expected %h, got %h", want.next_addr, got.next_addr);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.hand_off !== want.hand_off) begin
                    $error("hand_off: expected %0b, got %0b", want.hand_off, got.hand_off);
                    fail_count++;
                end
                if (got.reg_value !== want.reg_value) begin
                    $error("reg_value: expected %h, got %h", want.reg_value, got.reg_value);
                    fail_count++;
                end
                if (got.was_skipped !== want.was_skipped) begin
                    $error("was_skipped: expected %0b, got %0b",
                           want.was_skipped, got.was_skipped);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, none while steady, one long hold-off on request
    initial begin : result_backpressure
        m_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 11);
            end
        end
    end

    initial begin : main_flow
        t_dir_row row;

        rst_n      = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        fail_count = 0;
        depth      = 0;
        frame      = 0;
        script_reg = '0;
        nap_first  = '0;
        nap_second = '0;
        skip_state = SKIP_NONE;
        size_shift = 1'b0;
        foreach (ret_written[i]) ret_written[i] = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, run with the reset size shift.
        // Stack empty: pops, repeat end and exit all error out in place.
        add_row(make_command(OP_RETURN, 32'h100, 8'd4, CMP_AND, 16'h0, 0, 0, 0),
                1'b1, outcome(32'h100, ST_ERROR, 1'b0, 32'h0, 1'b0));
        add_row(make_command(OP_REPEAT_END, 32'h104, 8'd4, CMP_AND, 16'h0, 0, 0, 0),
                1'b1, outcome(32'h104, ST_ERROR, 1'b0, 32'h0, 1'b0));
        add_row(make_command(OP_EXIT, 32'h108, 8'd4, CMP_AND, 16'h0, 0, 0, 0),
                1'b1, outcome(32'h108, ST_ERROR, 1'b0, 32'h0, 1'b0));
        // undefined opcode at the top of the address space
        add_row(make_command(OP_TOP_CODE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                1'b1, outcome(32'hFFFF_FFFF, ST_ERROR, 1'b0, 32'h0, 1'b0));
        // register load at both ends of the half argument
        add_row(make_command(OP_SET_REG, 32'h200, 8'd4, CMP_AND, 16'h8000, 0, 0, 0),
                1'b1, outcome(32'h204, ST_RUN, 1'b0, 32'hFFFF_8000, 1'b0));
        add_row(make_command(OP_SET_REG, 32'h204, 8'd0, CMP_AND, 16'h7FFF, 0, 0, 0),
                1'b1, outcome(32'h204, ST_RUN, 1'b0, 32'h0000_7FFF, 1'b0));
        // address wrap on the fall-through
        add_row(make_command(OP_CALL_EXT, 32'hFFFF_FFFC, 8'd8, CMP_AND, 16'h0, 0, 0,
                             32'h8000_0000),
                1'b1, outcome(32'h4, ST_RUN, 1'b1, 32'h8000_0000, 1'b0));
        // call-loop pauses on a zero return and moves on otherwise
        add_row(make_command(OP_CALL_LOOP, 32'h300, 8'd4, CMP_AND, 16'h0, 0, 0, 32'h0),
                1'b1, outcome(32'h300, ST_PAUSE, 1'b1, 32'h0, 1'b0));
        add_row(make_command(OP_CALL_LOOP, 32'h300, 8'd4, CMP_AND, 16'h0, 0, 0,
                             32'h7FFF_FFFF),
                1'b1, outcome(32'h304, ST_RUN, 1'b1, 32'h7FFF_FFFF, 1'b0));
        // sleep counts down, then the zero-count sleep stays paused
        repeat (3) add_row(make_command(OP_SLEEP, 32'h400, 8'd4, CMP_AND, 16'd2, 0, 0, 0));
        add_row(make_command(OP_SLEEP2, 32'h410, 8'd4, CMP_AND, 16'd0, 0, 0, 0));
        // skip-if chain, then skip with its shorter chain
        add_row(make_command(OP_SKIP_IF, 32'h500, 8'd4, CMP_EQ, 16'h0, 32'h0, 0, 0));
        add_row(make_command(OP_SKIP, 32'h504, 8'd4, CMP_AND, 16'h0, 0, 0, 0));
        add_row(make_command(OP_SKIP_NOP, 32'h508, 8'd4, CMP_AND, 16'h0, 0, 0, 0));
        add_row(make_command(OP_JUMP, 32'h50C, 8'd4, CMP_AND, 16'h0, 0, 32'h9000, 0));
        add_row(make_command(OP_SKIP, 32'h510, 8'd4, CMP_AND, 16'h0, 0, 0, 0));
        add_row(make_command(OP_SKIP_IF, 32'h514, 8'd4, CMP_NE, 16'h0, 0, 0, 0));
        // variable get with the last valid index and one past it
        add_row(make_command(OP_VAR_ACCESS, 32'h600, 8'd4, 8'd1, 16'h0004, 0, 0,
                             32'h1234_5678));
        add_row(make_command(OP_VAR_ACCESS, 32'h604, 8'd4, 8'd1, 16'h0005, 0, 0,
                             32'hDEAD_BEEF));
        // compare op outside the defined set is false
        add_row(make_command(OP_JUMP_IF, 32'h608, 8'd4, 8'hFF, 16'h0, 32'h1234_5678,
                             32'hA000, 0));
        // frame with a zero-count repeat inside, handler opcodes, then leave
        add_row(make_command(OP_ENTER, 32'h700, 8'd8, CMP_AND, 16'h0, 0, 32'h1000, 0));
        add_row(make_command(OP_REPEAT, 32'h1000, 8'd4, CMP_AND, 16'h0, 0, 0, 0));
        add_row(make_command(OP_REPEAT_END, 32'h1004, 8'd4, CMP_AND, 16'h0, 0, 0, 0));
        add_row(make_command(OP_HANDLER_FIRST, 32'h1008, 8'd4, CMP_AND, 16'h0, 0, 0, 0));
        add_row(make_command(OP_HANDLER_LAST, 32'h100C, 8'd4, CMP_AND, 16'h0, 0, 0, 0));
        add_row(make_command(OP_EXIT, 32'h1010, 8'd4, CMP_AND, 16'h0, 0, 0, 0));

        while (dir_rows.size() != 0) begin
            row = dir_rows.pop_front();
            issue_command(row.item, row.typed, row.want);
        end
        s_valid <= 1'b0;
        settle();

        // Doubled sizes; the receiver holds off for a long stretch early on
        write_shift(1'b1);
        hold_req = 1'b1;
        run_random(450);
        s_valid <= 1'b0;
        settle();

        // Back to plain sizes; the first part runs with no idling on either side
        write_shift(1'b0);
        steady = 1'b1;
        run_random(200);
        steady = 1'b0;
        run_random(250);
        s_valid <= 1'b0;
        settle();

        write_shift(1'b1);
        run_random(450);
        s_valid <= 1'b0;
        settle();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/cls_pkg.sv
rtl/command_list_sequencer_core.sv
tb/tb_command_list_sequencer_core.sv
